// ===== rtl/core/urm_pkg.sv =====
// ----------------------------------------------------------------------------
// urm_pkg - shared definitions for the ultrasonic range meter
// Widths, register indexes and the speed-of-sound table function.
// ----------------------------------------------------------------------------
`default_nettype none

package urm_pkg;

	localparam int COUNT_BITS      = 20;
	localparam int SPEED_FRAC_BITS = 24;

	// speed of sound stays below 1/16 cm/us, so four fraction msbs are always zero
	localparam int SPEED_W    = SPEED_FRAC_BITS - 4;
	localparam int MAXD_W     = 10;
	localparam int TEMP_W     = 8;
	localparam int TRIG_W     = 8;
	localparam int LIM5_W     = 13;
	localparam int SUM_W      = SPEED_FRAC_BITS + 13;
	localparam int PSUM_W     = COUNT_BITS + SPEED_W + 1;
	localparam int DIST_SHIFT = SPEED_FRAC_BITS - 7;
	localparam int D_W        = PSUM_W - DIST_SHIFT;
	localparam int DIST_W     = 18;
	localparam int TICKS_W    = 20;

	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 48;
	localparam int M_PAD_W   = M_TDATA_W - (4 + DIST_W + TICKS_W);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [63:0] SPEED_DEN  = 64'd10000000;
	localparam logic [63:0] SPEED_HALF = 64'd5000000;
	localparam logic [PSUM_W-1:0] ROUND_HALF = PSUM_W'(64'd1 << (SPEED_FRAC_BITS - 8));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DIST  = 2'd0,
		REG_AIR_TEMP  = 2'd1,
		REG_TRIG_LOW  = 2'd2,
		REG_TRIG_HIGH = 2'd3
	} cfg_reg_t;

	// speed in cm/us, Q0.SPEED_FRAC_BITS, rounded half up
	function automatic logic [SPEED_W-1:0] speed_for_temp(input logic signed [TEMP_W-1:0] temp);
		logic [63:0] num;
		num = 64'(331300 + 606 * int'(temp));
		return SPEED_W'(((num << SPEED_FRAC_BITS) + SPEED_HALF) / SPEED_DEN);
	endfunction

	localparam logic [SPEED_W-1:0] SPEED_RESET = speed_for_temp(8'sd20);

endpackage

`default_nettype wire

// ===== rtl/core/ultrasonic_range_meter.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_range_meter - trigger/echo timer for an ultrasonic ranging sensor
// Fires a trigger pulse on request, times the echo and reports the distance.
// ----------------------------------------------------------------------------
// Each input word is one 1 us tick carrying a start request and the sampled
// echo level; every accepted word yields exactly one result word. The block
// takes one word per clock unless the result side stalls: a word passes an
// input register and one step of logic into the result register. A start while
// idle holds the trigger low for trig_low_ticks, high for trig_high_ticks,
// then listens: echo-high ticks are counted from the first high tick until
// the echo falls, or until elapsed time times the speed of sound passes
// 2.5 x max_distance_cm. Distance is reported in Q10.8 cm with in_range set,
// or zero with in_range clear when it is zero or beyond max_distance_cm. The
// speed of sound comes from a temperature table looked up when air_temp_c is
// written; register writes take effect at once, also in the middle of a
// measurement.
`default_nettype none

module ultrasonic_range_meter (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [urm_pkg::S_TDATA_W-1:0]       s_tdata,   // start_req, echo_level, zero pad
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [urm_pkg::M_TDATA_W-1:0]            m_tdata,   // trigger_out, busy_res, done_res,
	                                                            // in_range, distance_q8[17:0],
	                                                            // pulse_ticks[19:0], zero pad
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [urm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [urm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import urm_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_LOW    = 2'd1,
		PH_HIGH   = 2'd2,
		PH_LISTEN = 2'd3
	} phase_t;

	// speed table over all temperature codes
	logic [SPEED_W-1:0] spd_tab [256];
	for (genvar g = 0; g < 256; g++) begin : g_spd
		localparam logic [SPEED_W-1:0] SPD = speed_for_temp($signed(8'(g)));
		assign spd_tab[g] = SPD;
	end

	// configuration
	logic [MAXD_W-1:0]  max_dist_q;
	logic [LIM5_W-1:0]  lim5_q;
	logic [SPEED_W-1:0] speed_q;
	logic [TRIG_W-1:0]  trig_low_q;
	logic [TRIG_W-1:0]  trig_high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q  <= MAXD_W'(400);
			lim5_q      <= LIM5_W'(2000);
			speed_q     <= SPEED_RESET;
			trig_low_q  <= TRIG_W'(2);
			trig_high_q <= TRIG_W'(10);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_DIST: begin
					max_dist_q <= cfg_data;
					lim5_q     <= (LIM5_W'(cfg_data) << 2) + LIM5_W'(cfg_data);
				end
				REG_AIR_TEMP:  speed_q     <= spd_tab[cfg_data[TEMP_W-1:0]];
				REG_TRIG_LOW:  trig_low_q  <= cfg_data[TRIG_W-1:0];
				REG_TRIG_HIGH: trig_high_q <= cfg_data[TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic valid_s1, start_s1, echo_s1;
	logic advance, fire;

	assign advance  = !m_tvalid || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			start_s1 <= 1'b0;
			echo_s1  <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			start_s1 <= s_tdata[0];
			echo_s1  <= s_tdata[1];
		end
	end

	// measurement state
	phase_t                phase_q;
	logic [TRIG_W-1:0]     phase_cnt_q;
	logic [SUM_W-1:0]      sum_q;
	logic [COUNT_BITS-1:0] echo_cnt_q;
	logic                  echo_seen_q;

	phase_t                phase_d;
	logic [TRIG_W-1:0]     phase_cnt_d;
	logic [SUM_W-1:0]      sum_d;
	logic [COUNT_BITS-1:0] echo_cnt_d;
	logic                  echo_seen_d;

	logic                  trig, busy, done, inr;
	logic [DIST_W-1:0]     dist_out;
	logic [TICKS_W-1:0]    ticks;

	logic [TRIG_W-1:0]     low_len, high_len, cnt_inc;
	logic [SUM_W-1:0]      limit;
	logic [PSUM_W-1:0]     prod_rnd;
	logic [D_W-1:0]        dist_full;
	logic                  timeout, finish;

	assign low_len   = (trig_low_q == '0) ? TRIG_W'(1) : trig_low_q;
	assign high_len  = (trig_high_q == '0) ? TRIG_W'(1) : trig_high_q;
	assign limit     = SUM_W'(lim5_q) << (SPEED_FRAC_BITS - 1);
	assign timeout   = sum_q > limit;
	// count times current speed, upper operand bits are zero so this is 20 x 20
	assign prod_rnd  = PSUM_W'(echo_cnt_q) * PSUM_W'(speed_q) + ROUND_HALF;
	assign dist_full = prod_rnd[PSUM_W-1:DIST_SHIFT];

	always_comb begin
		phase_d     = phase_q;
		phase_cnt_d = phase_cnt_q;
		sum_d       = sum_q;
		echo_cnt_d  = echo_cnt_q;
		echo_seen_d = echo_seen_q;
		trig        = 1'b0;
		busy        = 1'b0;
		done        = 1'b0;
		inr         = 1'b0;
		dist_out    = '0;
		ticks       = '0;
		finish      = 1'b0;

		if (phase_d == PH_IDLE && start_s1) begin
			phase_d     = PH_LOW;
			phase_cnt_d = '0;
		end
		cnt_inc = phase_cnt_d + TRIG_W'(1);

		case (phase_d)
			PH_LOW: begin
				busy        = 1'b1;
				phase_cnt_d = cnt_inc;
				if (cnt_inc >= low_len) begin
					phase_d     = PH_HIGH;
					phase_cnt_d = '0;
				end
			end
			PH_HIGH: begin
				busy        = 1'b1;
				trig        = 1'b1;
				phase_cnt_d = cnt_inc;
				if (cnt_inc >= high_len) begin
					phase_d     = PH_LISTEN;
					phase_cnt_d = '0;
					sum_d       = '0;
					echo_cnt_d  = '0;
					echo_seen_d = 1'b0;
				end
			end
			PH_LISTEN: begin
				busy = 1'b1;
				if (timeout) begin
					finish = 1'b1;
				end else if (echo_s1) begin
					echo_seen_d = 1'b1;
					// saturating count
					if (echo_cnt_q != '1) begin
						echo_cnt_d = echo_cnt_q + COUNT_BITS'(1);
					end
				end else if (echo_seen_q) begin
					finish = 1'b1;
				end
				if (!finish) begin
					sum_d = sum_q + SUM_W'(speed_q);
				end else begin
					done  = 1'b1;
					ticks = TICKS_W'(echo_cnt_q);
					if (dist_full != '0 && dist_full <= (D_W'(max_dist_q) << 8)) begin
						inr      = 1'b1;
						dist_out = dist_full[DIST_W-1:0];
					end
					phase_d     = PH_IDLE;
					phase_cnt_d = '0;
					sum_d       = '0;
					echo_cnt_d  = '0;
					echo_seen_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			phase_cnt_q <= '0;
			sum_q       <= '0;
			echo_cnt_q  <= '0;
			echo_seen_q <= 1'b0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
		end else begin
			if (fire) begin
				phase_q     <= phase_d;
				phase_cnt_q <= phase_cnt_d;
				sum_q       <= sum_d;
				echo_cnt_q  <= echo_cnt_d;
				echo_seen_q <= echo_seen_d;
				m_tdata     <= {M_PAD_W'(0), ticks, dist_out, inr, done, busy, trig};
			end
			if (advance) begin
				m_tvalid <= valid_s1;
			end
		end
	end

	// result word consistency
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1])
		else $error("done word without busy");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[21:4] == '0)
		else $error("distance nonzero while out of range");

	a_idle_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[M_TDATA_W-1:3] == '0)
		else $error("result fields set without done");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> sum_q == '0 && echo_cnt_q == '0 && !echo_seen_q)
		else $error("listen state left over in idle");

	a_trig_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fire && trig |-> phase_q == PH_HIGH)
		else $error("trigger high outside the pulse phase");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking bench for ultrasonic_range_meter
// Streams 1 us ticks with start requests and echo levels into the meter. Each
// accepted tick is run through a tick-by-tick predictor of the trigger, echo
// timing and distance arithmetic. Every result word is compared field by
// field in order. Register settings change between measurement batches, and
// both stream sides idle at random.
// ----------------------------------------------------------------------------

module testbench;

	import urm_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 300;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOW,
		ST_HIGH,
		ST_LISTEN
	} meter_phase_t;

	// result word as packed on m_tdata, lowest bit last in this list
	typedef struct packed {
		logic [TICKS_W-1:0] ticks;
		logic [DIST_W-1:0]  distance;
		logic               in_range;
		logic               done;
		logic               busy;
		logic               trig;
	} meter_word_t;

	class echo_range_checker;
		logic [MAXD_W-1:0]        max_dist;
		logic signed [TEMP_W-1:0] air_temp;
		logic [TRIG_W-1:0]        trig_low;
		logic [TRIG_W-1:0]        trig_high;
		meter_phase_t             ph;
		logic [7:0]               ph_count;
		logic [63:0]              speed_sum;
		logic [COUNT_BITS-1:0]    echo_cnt;
		bit                       seen;
		meter_word_t              pending_words[$];
		int                       failures;
		int                       shown;
		int                       n_items;
		int                       n_done;

		function new();
			max_dist  = 10'd400;
			air_temp  = 8'sd20;
			trig_low  = 8'd2;
			trig_high = 8'd10;
			ph        = ST_IDLE;
			ph_count  = '0;
			speed_sum = '0;
			echo_cnt  = '0;
			seen      = 1'b0;
			failures  = 0;
			shown     = 0;
			n_items   = 0;
			n_done    = 0;
		endfunction

		// cm/us in Q0.24, rounded half up
		function logic [63:0] speed_q();
			logic [63:0] num;
			num = 64'(331300 + 606 * int'(air_temp));
			return ((num << SPEED_FRAC_BITS) + 64'd5000000) / 64'd10000000;
		endfunction

		function logic [63:0] timeout_sum();
			return (64'(max_dist) * 64'd5) << (SPEED_FRAC_BITS - 1);
		endfunction

		function int unsigned timeout_ticks();
			return int'(timeout_sum() / speed_q()) + 1;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_MAX_DIST:  max_dist  = value[MAXD_W-1:0];
				REG_AIR_TEMP:  air_temp  = value[TEMP_W-1:0];
				REG_TRIG_LOW:  trig_low  = value[TRIG_W-1:0];
				REG_TRIG_HIGH: trig_high = value[TRIG_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_tick(bit start, bit echo);
			meter_word_t w;
			logic [63:0] spd;
			logic [63:0] d;
			logic [7:0]  len;
			bit          finish;
			w = '0;
			finish = 1'b0;
			n_items++;
			if (ph == ST_IDLE && start) begin
				ph = ST_LOW;
				ph_count = '0;
			end
			case (ph)
				ST_LOW: begin
					len = (trig_low == 0) ? 8'd1 : trig_low;
					w.busy = 1'b1;
					ph_count = ph_count + 8'd1;
					if (ph_count >= len) begin
						ph = ST_HIGH;
						ph_count = '0;
					end
				end
				ST_HIGH: begin
					len = (trig_high == 0) ? 8'd1 : trig_high;
					w.busy = 1'b1;
					w.trig = 1'b1;
					ph_count = ph_count + 8'd1;
					if (ph_count >= len) begin
						ph = ST_LISTEN;
						ph_count = '0;
						speed_sum = '0;
						echo_cnt = '0;
						seen = 1'b0;
					end
				end
				ST_LISTEN: begin
					spd = speed_q();
					w.busy = 1'b1;
					// timeout is tested before the echo is looked at
					if (speed_sum > timeout_sum()) begin
						finish = 1'b1;
					end else if (echo) begin
						seen = 1'b1;
						if (echo_cnt != '1)
							echo_cnt = echo_cnt + 1'b1;
					end else if (seen) begin
						finish = 1'b1;
					end
					if (!finish) begin
						speed_sum = speed_sum + spd;
					end else begin
						d = (64'(echo_cnt) * spd + (64'd1 << (SPEED_FRAC_BITS - 8)))
							>> (SPEED_FRAC_BITS - 7);
						w.done = 1'b1;
						w.ticks = echo_cnt;
						if (d != 0 && d <= (64'(max_dist) << 8)) begin
							w.in_range = 1'b1;
							w.distance = d[DIST_W-1:0];
						end
						n_done++;
						ph = ST_IDLE;
						ph_count = '0;
						speed_sum = '0;
						echo_cnt = '0;
						seen = 1'b0;
					end
				end
				default: ;
			endcase
			pending_words.push_back(w);
		endfunction

		function void check_word(logic [$bits(meter_word_t)-1:0] raw);
			meter_word_t got;
			meter_word_t want;
			got = meter_word_t'(raw);
			if (pending_words.size() == 0) begin
				failures++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result word %h", raw);
				end
				return;
			end
			want = pending_words.pop_front();
			if (got.trig !== want.trig || got.busy !== want.busy || got.done !== want.done ||
			    got.in_range !== want.in_range || got.distance !== want.distance ||
			    got.ticks !== want.ticks) begin
				failures++;
				if (shown < 10) begin
					shown++;
					$display("mismatch: exp trig %b busy %b done %b inr %b dist %0d ticks %0d",
						want.trig, want.busy, want.done, want.in_range, want.distance,
						want.ticks);
					$display("          got trig %b busy %b done %b inr %b dist %0d ticks %0d",
						got.trig, got.busy, got.done, got.in_range, got.distance, got.ticks);
				end
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_W-1:0]    s_tdata = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [M_TDATA_W-1:0]    m_tdata;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_MAX_DIST;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	echo_range_checker chk;
	bit gaps_on = 1'b0;
	bit hold_rx = 1'b0;
	int stall_cycles = 0;

	ultrasonic_range_meter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// result side: random stalls plus one long hold-off on request
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				hold_rx = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					repeat (stall - 1) @(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			chk.check_word(m_tdata[$bits(meter_word_t)-1:0]);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_tick(bit start, bit echo);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'({echo, start});
		do @(posedge clk); while (!s_tready);
		chk.take_tick(start, echo);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		chk.write_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// brings a running measurement to a quick end: one echo tick, then low
	task automatic drain();
		while (chk.ph != ST_IDLE)
			send_tick(1'b0, chk.ph == ST_LISTEN && !chk.seen);
	endtask

	task automatic settle();
		drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (chk.pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic setup(int maxd, int temp, int tlow, int thigh);
		settle();
		write_reg(REG_MAX_DIST, CFG_DATA_W'(maxd));
		write_reg(REG_AIR_TEMP, CFG_DATA_W'(TEMP_W'(temp)));
		write_reg(REG_TRIG_LOW, CFG_DATA_W'(tlow));
		write_reg(REG_TRIG_HIGH, CFG_DATA_W'(thigh));
	endtask

	// start, trigger pulse, then echo low for delay ticks and high for width;
	// a width of zero runs into the timeout
	task automatic measure(int unsigned delay, int unsigned width);
		int unsigned n;
		drain();
		send_tick(1'b1, 1'($urandom_range(0, 1)));
		while (chk.ph != ST_LISTEN)
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		n = 0;
		while (chk.ph == ST_LISTEN) begin
			send_tick(1'($urandom_range(0, 1)), n >= delay && n < delay + width);
			n++;
		end
	endtask

	task automatic random_measure();
		int unsigned tout;
		int unsigned width;
		int r;
		tout = chk.timeout_ticks();
		r = $urandom_range(0, 9);
		if (r == 0)
			width = 0;
		else if (r == 1)
			width = 1;
		else
			width = $urandom_range(1, tout);
		measure($urandom_range(0, tout / 3), width);
	endtask

	initial begin
		int maxd;
		int temp;
		int tlow;
		int thigh;
		bit held;
		held = 1'b0;
		chk = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings, no idling
		measure(3, 10);
		measure(0, 1);

		// upper extremes of range and trigger lengths
		gaps_on = 1'b1;
		setup(1023, 85, 255, 255);
		measure(5, 600);

		// smallest range: short echo in range, timeout with no echo, echo beyond range, echo cut by timeout
		setup(1, -40, 1, 1);
		measure(0, 1);
		measure(10, 0);
		measure(0, 75);
		measure(2, 200);

		// zero trigger lengths and zero range
		setup(0, -128, 0, 0);
		measure(0, 1);
		measure(0, 0);
		setup(3, 127, 1, 0);
		measure(1, 40);
		measure(0, 500);

		while (chk.n_items < 2000) begin
			maxd = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, 12);
			temp = ($urandom_range(0, 99) < 80) ? int'($urandom_range(0, 125)) - 40
				: int'($urandom_range(0, 255)) - 128;
			tlow = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 6)
				: (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(7, 255));
			thigh = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 12)
				: (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 255));
			setup(maxd, temp, tlow, thigh);
			gaps_on = ($urandom_range(0, 5) != 0);
			repeat (6) begin
				if ($urandom_range(0, 9) < 8)
					random_measure();
				else
					repeat ($urandom_range(5, 40))
						send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				if (!held && chk.n_items > 300) begin
					hold_rx = 1'b1;
					held = 1'b1;
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (chk.failures == 0 && chk.pending_words.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/urm_pkg.sv
rtl/core/ultrasonic_range_meter.sv
sim/testbench.sv
